[rtl/core/assert_macros.svh]
// assertion macros used by the checker file jms_checker
// expects signals named clock and reset in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, off while reset is high
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// implication check, off while reset is high
`define ASSERT_IMPL(label, ante, cons, msg) \
   `ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

[rtl/core/jms_pkg.sv]
// jms_pkg: item types, parse modes, byte classes and marker codes
// used by the core, parser and checker files of the codestream marker segmenter; no dependencies
`timescale 1ns / 1ps

package jms_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       restart;
   } req_type;

   typedef struct packed {
      logic [2:0]  byte_class;
      logic [7:0]  marker_code;
      logic [15:0] payload_offset;
      logic        segment_last;
      logic        codestream_done;
      logic        length_error;
   } rsp_type;

   // parse modes
   localparam logic [2:0] MODE_HUNT     = 3'd0;
   localparam logic [2:0] MODE_LEN_HI   = 3'd1;
   localparam logic [2:0] MODE_LEN_LO   = 3'd2;
   localparam logic [2:0] MODE_PAYLOAD  = 3'd3;
   localparam logic [2:0] MODE_SCAN_CNT = 3'd4;
   localparam logic [2:0] MODE_SCAN_OPN = 3'd5;
   localparam logic [2:0] MODE_DONE     = 3'd6;
   localparam logic [2:0] MODE_ERROR    = 3'd7;

   // byte classes
   localparam logic [2:0] CLASS_SKIPPED   = 3'd0;
   localparam logic [2:0] CLASS_PREFIX    = 3'd1;
   localparam logic [2:0] CLASS_MARKER    = 3'd2;
   localparam logic [2:0] CLASS_LENGTH    = 3'd3;
   localparam logic [2:0] CLASS_PAYLOAD   = 3'd4;
   localparam logic [2:0] CLASS_SCAN      = 3'd5;
   localparam logic [2:0] CLASS_ESCAPED   = 3'd6;
   localparam logic [2:0] CLASS_AFTER_END = 3'd7;

   // marker codes and byte values
   localparam logic [7:0] BYTE_FF     = 8'hff;
   localparam logic [7:0] BYTE_ZERO   = 8'h00;
   localparam logic [7:0] MARKER_SOC  = 8'h4f;
   localparam logic [7:0] MARKER_SOT  = 8'h90;
   localparam logic [7:0] MARKER_EPH  = 8'h92;
   localparam logic [7:0] MARKER_SOD  = 8'h93;
   localparam logic [7:0] MARKER_EOC  = 8'hd9;
   localparam logic [7:0] MARKER_RES_LO = 8'h30;
   localparam logic [7:0] MARKER_RES_HI = 8'h3f;

   localparam logic [15:0] SOT_MIN_LEN = 16'd10;
   localparam logic [31:0] SOT_HDR_LEN = 32'd10;

   function automatic logic has_no_params(input logic [7:0] code);
      has_no_params = (code == MARKER_SOC) || (code == MARKER_EPH) ||
                      (code == MARKER_SOD) || (code == MARKER_EOC) ||
                      ((code >= MARKER_RES_LO) && (code <= MARKER_RES_HI));
   endfunction

endpackage

[rtl/core/jpeg2000_marker_segmenter_core.sv]
// JPEG 2000 codestream marker segmenter, top level
// input register, jms_parser and result register; depends on jms_pkg
//
// usage:
//   req_ carries one codestream byte per item (data_byte, restart); restart
//   clears the parse state before that byte is handled.
//   rsp_ returns exactly one tagged item per input byte, in order.
//   both channels hand over an item on a clock edge where valid is high and
//   stall is low.
// path: the input register takes the byte, then the result register loads its tag
//   once the result register is free (empty, or rsp_stall low).
// throughput: 1 item per cycle while rsp_stall is low; the parse state update is a single compare
//   and counter step between the input and result registers.
// stall: when rsp_stall holds a result, the result register keeps it and the
//   input register can still take one more item; req_stall then goes high.
// reset: clears both valid bits and the parse state (hunting for a marker).
`timescale 1ns / 1ps

module jpeg2000_marker_segmenter_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  jms_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output jms_pkg::rsp_type rsp_payload
);

   logic             in_valid_ff, in_valid_in;
   jms_pkg::req_type in_item_ff;
   logic             out_valid_ff, out_valid_in;
   jms_pkg::rsp_type out_item_ff;
   jms_pkg::rsp_type step_result;
   logic             out_open;
   logic             step_en;
   logic             req_take;

   assign out_open  = !out_valid_ff || !rsp_stall;
   assign step_en   = in_valid_ff && out_open;
   assign req_stall = in_valid_ff && !out_open;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = (in_valid_ff && !out_open) || req_take;
   assign out_valid_in = out_open ? in_valid_ff : out_valid_ff;

   jms_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .step_en(step_en),
      .item   (in_item_ff),
      .result (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_payload;
      end
      if (step_en) begin
         out_item_ff <= step_result;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_item_ff;

endmodule

[rtl/core/jms_parser.sv]
// jms_parser: parse state registers and the per-byte classify and update logic
// depends on jms_pkg
`timescale 1ns / 1ps

module jms_parser (
   input  logic            clock,
   input  logic            reset,
   input  logic            step_en,
   input  jms_pkg::req_type item,
   output jms_pkg::rsp_type result
);

   logic [2:0]  mode_ff, mode_in;
   logic        prefix_ff, prefix_in;
   logic [7:0]  marker_ff, marker_in;
   logic [15:0] seg_len_ff, seg_len_in;
   logic [15:0] pcount_ff, pcount_in;
   logic [31:0] tp_rem_ff, tp_rem_in;
   logic        tp_valid_ff, tp_valid_in;
   logic [31:0] scan_rem_ff, scan_rem_in;

   logic [2:0]  cur_mode;
   logic [15:0] cur_pcount;
   logic [15:0] pcount_inc;
   logic [31:0] psot;
   logic        take_mk;
   logic [7:0]  b;

   always_comb begin
      b           = item.data_byte;
      mode_in     = mode_ff;
      prefix_in   = prefix_ff;
      marker_in   = marker_ff;
      seg_len_in  = seg_len_ff;
      pcount_in   = pcount_ff;
      tp_rem_in   = tp_rem_ff;
      tp_valid_in = tp_valid_ff;
      scan_rem_in = scan_rem_ff;
      take_mk     = 1'b0;
      psot        = '0;
      result      = '0;

      if (item.restart) begin
         mode_in     = jms_pkg::MODE_HUNT;
         prefix_in   = 1'b0;
         marker_in   = '0;
         seg_len_in  = '0;
         pcount_in   = '0;
         tp_rem_in   = '0;
         tp_valid_in = 1'b0;
         scan_rem_in = '0;
      end
      cur_mode   = mode_in;
      cur_pcount = pcount_in;
      pcount_inc = cur_pcount + 16'd1;

      // psot countdown runs on every byte once captured
      if (tp_valid_in && (tp_rem_in != '0)) begin
         tp_rem_in = tp_rem_in - 32'd1;
      end

      unique case (cur_mode)
         jms_pkg::MODE_HUNT: begin
            if (b == jms_pkg::BYTE_FF) begin
               prefix_in         = 1'b1;
               result.byte_class = jms_pkg::CLASS_PREFIX;
            end else if (!prefix_in) begin
               result.byte_class = jms_pkg::CLASS_SKIPPED;
            end else if (b == jms_pkg::BYTE_ZERO) begin
               prefix_in         = 1'b0;
               result.byte_class = jms_pkg::CLASS_ESCAPED;
            end else begin
               take_mk = 1'b1;
            end
         end
         jms_pkg::MODE_LEN_HI: begin
            result.byte_class = jms_pkg::CLASS_LENGTH;
            seg_len_in        = {b, 8'h00};
            mode_in           = jms_pkg::MODE_LEN_LO;
         end
         jms_pkg::MODE_LEN_LO: begin
            result.byte_class = jms_pkg::CLASS_LENGTH;
            seg_len_in        = {seg_len_in[15:8], b};
            if (seg_len_in < 16'd2) begin
               result.length_error = 1'b1;
               mode_in             = jms_pkg::MODE_ERROR;
            end else if (seg_len_in == 16'd2) begin
               result.segment_last = 1'b1;
               mode_in             = jms_pkg::MODE_HUNT;
            end else begin
               pcount_in = '0;
               mode_in   = jms_pkg::MODE_PAYLOAD;
            end
         end
         jms_pkg::MODE_PAYLOAD: begin
            result.byte_class     = jms_pkg::CLASS_PAYLOAD;
            result.payload_offset = cur_pcount;
            // psot sits in sot payload bytes 2..5, big-endian
            if ((marker_in == jms_pkg::MARKER_SOT) && (seg_len_in >= jms_pkg::SOT_MIN_LEN) &&
                (cur_pcount >= 16'd2) && (cur_pcount <= 16'd5)) begin
               if (cur_pcount == 16'd2) begin
                  tp_rem_in = {24'h000000, b};
               end else begin
                  tp_rem_in = {tp_rem_in[23:0], b};
               end
               if (cur_pcount == 16'd5) begin
                  psot        = tp_rem_in;
                  tp_valid_in = (psot != '0);
                  tp_rem_in   = (psot > jms_pkg::SOT_HDR_LEN) ?
                                psot - jms_pkg::SOT_HDR_LEN : '0;
               end
            end
            pcount_in = pcount_inc;
            if (pcount_inc >= (seg_len_in - 16'd2)) begin
               result.segment_last = 1'b1;
               mode_in             = jms_pkg::MODE_HUNT;
            end
         end
         jms_pkg::MODE_SCAN_CNT: begin
            result.byte_class = jms_pkg::CLASS_SCAN;
            if (scan_rem_in != '0) begin
               scan_rem_in = scan_rem_in - 32'd1;
            end
            if (scan_rem_in == '0) begin
               result.segment_last = 1'b1;
               prefix_in           = 1'b0;
               mode_in             = jms_pkg::MODE_HUNT;
            end
         end
         jms_pkg::MODE_SCAN_OPN: begin
            if (b == jms_pkg::BYTE_FF) begin
               prefix_in         = 1'b1;
               result.byte_class = jms_pkg::CLASS_PREFIX;
            end else if (!prefix_in) begin
               result.byte_class = jms_pkg::CLASS_SCAN;
            end else if (b == jms_pkg::BYTE_ZERO) begin
               prefix_in         = 1'b0;
               result.byte_class = jms_pkg::CLASS_ESCAPED;
            end else if (b < jms_pkg::MARKER_SOT) begin
               prefix_in         = 1'b0;
               result.byte_class = jms_pkg::CLASS_SCAN;
            end else begin
               take_mk = 1'b1;
            end
         end
         jms_pkg::MODE_ERROR: begin
            result.byte_class   = jms_pkg::CLASS_AFTER_END;
            result.length_error = 1'b1;
         end
         default: begin
            result.byte_class = jms_pkg::CLASS_AFTER_END;
         end
      endcase

      if (take_mk) begin
         prefix_in         = 1'b0;
         marker_in         = b;
         result.byte_class = jms_pkg::CLASS_MARKER;
         if (jms_pkg::has_no_params(b)) begin
            if (b == jms_pkg::MARKER_EOC) begin
               result.codestream_done = 1'b1;
               mode_in                = jms_pkg::MODE_DONE;
            end else if (b == jms_pkg::MARKER_SOD) begin
               if (tp_valid_in) begin
                  scan_rem_in = tp_rem_in;
                  tp_valid_in = 1'b0;
                  tp_rem_in   = '0;
                  if (scan_rem_in == '0) begin
                     result.segment_last = 1'b1;
                     mode_in             = jms_pkg::MODE_HUNT;
                  end else begin
                     mode_in = jms_pkg::MODE_SCAN_CNT;
                  end
               end else begin
                  mode_in = jms_pkg::MODE_SCAN_OPN;
               end
            end else begin
               mode_in = jms_pkg::MODE_HUNT;
            end
         end else begin
            if (b == jms_pkg::MARKER_SOT) begin
               tp_valid_in = 1'b0;
               tp_rem_in   = '0;
            end
            mode_in = jms_pkg::MODE_LEN_HI;
         end
      end

      result.marker_code = marker_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= jms_pkg::MODE_HUNT;
         prefix_ff   <= 1'b0;
         marker_ff   <= '0;
         seg_len_ff  <= '0;
         pcount_ff   <= '0;
         tp_rem_ff   <= '0;
         tp_valid_ff <= 1'b0;
         scan_rem_ff <= '0;
      end else if (step_en) begin
         mode_ff     <= mode_in;
         prefix_ff   <= prefix_in;
         marker_ff   <= marker_in;
         seg_len_ff  <= seg_len_in;
         pcount_ff   <= pcount_in;
         tp_rem_ff   <= tp_rem_in;
         tp_valid_ff <= tp_valid_in;
         scan_rem_ff <= scan_rem_in;
      end
   end

endmodule

[rtl/core/jms_checker.sv]
// jms_checker: port-level checks on the marker segmenter top level, and its bind
// depends on jms_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jms_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input jms_pkg::req_type req_payload,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input jms_pkg::rsp_type rsp_payload
);

   logic [1:0] pending_ff, pending_in;
   logic       req_fire;
   logic       rsp_fire;
   logic [2:0] cls;

   assign req_fire = req_valid && !req_stall;
   assign rsp_fire = rsp_valid && !rsp_stall;
   assign cls      = rsp_payload.byte_class;

   // items accepted but not yet delivered
   always_comb begin
      pending_in = pending_ff;
      if (req_fire && !rsp_fire) begin
         pending_in = pending_ff + 2'd1;
      end else if (!req_fire && rsp_fire) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `ASSERT_IMPL(a_rsp_hold, rsp_valid && rsp_stall, ##1 (rsp_valid && $stable(rsp_payload)), "stalled item changed")
   `ASSERT_IMPL(a_no_extra_item, rsp_valid, pending_ff != 2'd0, "item delivered with nothing in flight")
   `ASSERT_CLK(a_in_flight_bound, pending_ff <= 2'd2, "more than two items in flight")
   `ASSERT_IMPL(a_done_on_eoc, rsp_valid && rsp_payload.codestream_done, (cls == jms_pkg::CLASS_MARKER) && (rsp_payload.marker_code == jms_pkg::MARKER_EOC), "done flag off an eoc code")
   `ASSERT_IMPL(a_last_class, rsp_valid && rsp_payload.segment_last, (cls == jms_pkg::CLASS_LENGTH) || (cls == jms_pkg::CLASS_PAYLOAD) || (cls == jms_pkg::CLASS_SCAN) || (cls == jms_pkg::CLASS_MARKER), "segment end on a wrong class")

endmodule

bind jpeg2000_marker_segmenter_core jms_checker u_jms_checker (.*);
